// ----- hdl/rsr_pkg.sv -----
// shared types, constants and helpers for request segmentation and reassembly
package rsr_pkg;

	localparam int ADDR_W        = 34;
	localparam int TAG_W         = 9;
	localparam int SIZE_W        = 9;
	localparam int FLIT_W        = 5;
	localparam int CNT_W         = 4;
	localparam int LG_W          = 4;
	localparam int VAULT_OUT_W   = 5;
	localparam int VAULT_COUNT   = 32;
	localparam int VAULT_W       = $clog2(VAULT_COUNT);
	localparam int MAX_REQ_BYTES = 256;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [LG_W-1:0] BLK_LG_RESET = 4'd6;
	localparam logic [LG_W-1:0] BLK_LG_MIN   = 4'd5;
	localparam logic [LG_W-1:0] BLK_LG_MAX   = 4'd8;

	localparam logic OP_DOWN = 1'b0;
	localparam logic OP_UP   = 1'b1;
	localparam logic DIR_VAULT = 1'b0;
	localparam logic DIR_LINK  = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] address;
		logic [SIZE_W-1:0] size_bytes;
		logic [TAG_W-1:0]  tag;
		logic [FLIT_W-1:0] flits;
		logic              is_segment;
		logic              first_segment;
	} rsr_in_t;

	typedef struct packed {
		logic                   direction;
		logic [VAULT_OUT_W-1:0] vault;
		logic [ADDR_W-1:0]      out_address;
		logic [TAG_W-1:0]       out_tag;
		logic [FLIT_W-1:0]      out_flits;
		logic                   out_segment;
		logic                   out_first;
		logic                   last;
		logic                   error;
	} rsr_out_t;

	typedef enum logic [1:0] {
		K_PASS_DOWN,
		K_SPLIT,
		K_PASS_UP,
		K_SEGMENT
	} rsr_kind_t;

	// classified request as it waits between front and back
	typedef struct packed {
		rsr_kind_t         kind;
		logic [ADDR_W-1:0] address;
		logic [TAG_W-1:0]  tag;
		logic [FLIT_W-1:0] flits;
		logic              first_segment;
		logic [CNT_W-1:0]  seg_cnt;
		logic [FLIT_W-1:0] seg_flits;
	} rsr_item_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_LOOKUP,
		B_EXEC,
		B_EMIT
	} rsr_back_state_t;

	typedef struct packed {
		logic             active;
		logic [CNT_W-1:0] pending;
	} rsr_tag_state_t;

	typedef struct packed {
		logic [FLIT_W-1:0] flits;
		logic [ADDR_W-1:0] address;
	} rsr_merge_t;

	typedef struct packed {
		logic              dir;
		logic [ADDR_W-1:0] addr;
		logic [TAG_W-1:0]  tag;
		logic [FLIT_W-1:0] flits;
		logic              seg;
		logic              first;
		logic              err;
		logic [CNT_W-1:0]  left;
	} rsr_emit_t;

	// out-of-range register values are pinned to the supported block sizes
	function automatic logic [LG_W-1:0] blk_lg(input logic [LG_W-1:0] raw);
		logic [LG_W-1:0] r;
		r = raw;
		if (raw < BLK_LG_MIN)
			r = BLK_LG_MIN;
		else if (raw > BLK_LG_MAX)
			r = BLK_LG_MAX;
		return r;
	endfunction

endpackage

// ----- hdl/request_segment_and_reassemble.sv -----
// flow: a request is registered in the front and queued, then the back end takes it through
//   idle, lookup and exec states and registers its results at one per cycle while result_stall
//   is low (n results for a split into n segments, none for a folded segment)
// reset: asynchronous, then a clearing pass over every entry of the pending table
//   during which no request is accepted; configuration writes are taken throughout
module request_segment_and_reassemble #(
	parameter int TAG_ENTRIES = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [rsr_pkg::LG_W-1:0] cfg_wdata,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  rsr_pkg::rsr_in_t         item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output rsr_pkg::rsr_out_t        result
);
	import rsr_pkg::*;

	localparam int IDX_W = $clog2(TAG_ENTRIES);
	localparam int Q_W   = $bits(rsr_item_t) + IDX_W;

	logic [LG_W-1:0]  cfg_q;
	logic [LG_W-1:0]  lg;
	logic             clearing;
	logic             q_full;
	logic             q_push;
	logic             q_valid;
	logic             q_pop;
	rsr_item_t        f_item;
	logic [IDX_W-1:0] f_idx;
	logic [Q_W-1:0]   q_rdata;
	rsr_item_t        b_item;
	logic [IDX_W-1:0] b_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= BLK_LG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	assign lg = blk_lg(cfg_q);
	assign {b_item, b_idx} = q_rdata;

	rsr_front #(
		.TAG_ENTRIES(TAG_ENTRIES),
		.IDX_W(IDX_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.lg(lg),
		.clearing(clearing),
		.q_full(q_full),
		.q_push(q_push),
		.q_item(f_item),
		.q_idx(f_idx)
	);

	rsr_fifo #(
		.WIDTH(Q_W)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata({f_item, f_idx}),
		.full(q_full),
		.valid(q_valid),
		.pop(q_pop),
		.rdata(q_rdata)
	);

	rsr_back #(
		.TAG_ENTRIES(TAG_ENTRIES),
		.IDX_W(IDX_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.lg(lg),
		.q_valid(q_valid),
		.q_item(b_item),
		.q_idx(b_idx),
		.q_pop(q_pop),
		.clearing(clearing),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// no request taken while the pending table is being cleared
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> item_stall)
		else $error("request accepted during clearing pass");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !result_valid)
		else $error("result shown during clearing pass");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.error) |-> (result.direction == DIR_LINK && result.last))
		else $error("error result not a single upstream result");

	a_link_vault: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.direction == DIR_LINK) |->
			(result.vault == '0 && !result.out_segment))
		else $error("upstream result carries vault or segment mark");

endmodule

// ----- hdl/rsr_front.sv -----
// front part: takes requests, reduces the tag, classifies and sizes the split
module rsr_front #(
	parameter int TAG_ENTRIES = 512,
	parameter int IDX_W       = 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  rsr_pkg::rsr_in_t           item,
	input  logic [rsr_pkg::LG_W-1:0]   lg,
	input  logic                       clearing,
	input  logic                       q_full,
	output logic                       q_push,
	output rsr_pkg::rsr_item_t         q_item,
	output logic [IDX_W-1:0]           q_idx
);
	import rsr_pkg::*;

	localparam int MOD_W = 17;

	rsr_in_t           item_s1;
	logic              valid_s1;
	logic              accept;
	logic [MOD_W-1:0]  rem;
	logic [SIZE_W-1:0] blk;
	logic [SIZE_W-1:0] size_c;
	logic [SIZE_W:0]   nsum;
	logic              split;

	assign item_stall = clearing || (valid_s1 && q_full);
	assign accept     = item_valid && !item_stall;
	assign q_push     = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// tag mod entry count by restoring subtraction, correct while the quotient stays below 32
	always_comb begin
		rem = MOD_W'(item_s1.tag);
		for (int k = 4; k >= 0; k--) begin
			if (rem >= (MOD_W'(TAG_ENTRIES) << k))
				rem = rem - (MOD_W'(TAG_ENTRIES) << k);
		end
	end

	assign q_idx = rem[IDX_W-1:0];

	always_comb begin
		blk    = SIZE_W'(1) << lg;
		size_c = (item_s1.size_bytes > SIZE_W'(MAX_REQ_BYTES)) ?
			SIZE_W'(MAX_REQ_BYTES) : item_s1.size_bytes;
		split  = size_c > blk;
		nsum   = (SIZE_W+1)'(size_c) + (SIZE_W+1)'(blk) - (SIZE_W+1)'(1);

		q_item.address       = item_s1.address;
		q_item.tag           = item_s1.tag;
		q_item.flits         = item_s1.flits;
		q_item.first_segment = item_s1.first_segment;
		q_item.seg_cnt       = CNT_W'(nsum >> lg);
		q_item.seg_flits     = (item_s1.flits > FLIT_W'(1)) ?
			FLIT_W'(FLIT_W'(1) + FLIT_W'(blk >> 4)) : item_s1.flits;

		if (item_s1.opcode == OP_DOWN)
			q_item.kind = split ? K_SPLIT : K_PASS_DOWN;
		else
			q_item.kind = item_s1.is_segment ? K_SEGMENT : K_PASS_UP;
	end

endmodule

// ----- hdl/rsr_fifo.sv -----
// short queue between the front and the back
module rsr_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	output logic             valid,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata
);
	import rsr_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign valid = cnt_q != '0;
	assign full  = cnt_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (PTR_W+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (PTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- hdl/rsr_back.sv -----
// back part: per-tag tables, segment emission and response merging
module rsr_back #(
	parameter int TAG_ENTRIES = 512,
	parameter int IDX_W       = 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [rsr_pkg::LG_W-1:0] lg,
	input  logic                     q_valid,
	input  rsr_pkg::rsr_item_t       q_item,
	input  logic [IDX_W-1:0]         q_idx,
	output logic                     q_pop,
	output logic                     clearing,
	output logic                     result_valid,
	input  logic                     result_stall,
	output rsr_pkg::rsr_out_t        result
);
	import rsr_pkg::*;

	rsr_back_state_t state_q, state_d;
	rsr_item_t       cur_q;
	logic [IDX_W-1:0] cur_idx_q;
	logic [IDX_W-1:0] clr_idx_q;
	rsr_emit_t       em_q, em_d;
	logic            em_load;
	logic            out_load;
	logic            out_valid_q;
	rsr_out_t        out_q;

	rsr_tag_state_t  state_mem [TAG_ENTRIES];
	rsr_merge_t      merge_mem [TAG_ENTRIES];
	rsr_tag_state_t  st_rd_q;
	rsr_merge_t      mg_rd_q;
	logic            st_we;
	rsr_tag_state_t  st_wdata;
	logic [IDX_W-1:0] st_widx;
	logic            mg_we;
	rsr_merge_t      mg_wdata;

	logic [ADDR_W-1:0] blk;
	logic [FLIT_W:0]   b16;
	logic [FLIT_W:0]   fsum;
	logic [CNT_W:0]    psum;
	logic [CNT_W-1:0]  pend_dec;
	logic [FLIT_W-1:0] m_flits;
	logic [ADDR_W-1:0] m_addr;
	logic [ADDR_W-1:0] addr_sh;

	assign clearing     = state_q == B_CLEAR;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign st_widx      = clearing ? clr_idx_q : cur_idx_q;

	assign blk     = ADDR_W'(1) << lg;
	assign b16     = (FLIT_W+1)'((SIZE_W'(1) << lg) >> 4);
	assign addr_sh = em_q.addr >> lg;

	// merge of a segment response into its tag entry
	always_comb begin
		fsum     = (FLIT_W+1)'(mg_rd_q.flits) + b16;
		psum     = (CNT_W+1)'(st_rd_q.pending) + (CNT_W+1)'(cur_q.seg_cnt);
		pend_dec = st_rd_q.pending - CNT_W'(1);
		if (st_rd_q.active) begin
			m_flits = mg_rd_q.flits;
			if (cur_q.flits > FLIT_W'(1))
				m_flits = (fsum > (FLIT_W+1)'(31)) ? FLIT_W'(31) : fsum[FLIT_W-1:0];
			m_addr = cur_q.first_segment ? cur_q.address : mg_rd_q.address;
		end else begin
			m_flits = cur_q.flits;
			m_addr  = cur_q.address;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		st_we    = 1'b0;
		st_wdata = '0;
		mg_we    = 1'b0;
		mg_wdata = '0;
		em_load  = 1'b0;
		em_d     = em_q;
		out_load = 1'b0;
		case (state_q)
			B_CLEAR: begin
				st_we = 1'b1;
				if (clr_idx_q == IDX_W'(TAG_ENTRIES - 1))
					state_d = B_IDLE;
			end
			B_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = B_LOOKUP;
				end
			end
			B_LOOKUP: begin
				state_d = B_EXEC;
			end
			B_EXEC: begin
				em_load    = 1'b1;
				state_d    = B_EMIT;
				em_d.dir   = DIR_VAULT;
				em_d.addr  = cur_q.address;
				em_d.tag   = cur_q.tag;
				em_d.flits = cur_q.flits;
				em_d.seg   = 1'b0;
				em_d.first = 1'b0;
				em_d.err   = 1'b0;
				em_d.left  = CNT_W'(1);
				case (cur_q.kind)
					K_SPLIT: begin
						st_we            = 1'b1;
						st_wdata.active  = st_rd_q.active;
						st_wdata.pending = (psum > (CNT_W+1)'(15)) ? CNT_W'(15) : psum[CNT_W-1:0];
						em_d.flits       = cur_q.seg_flits;
						em_d.seg         = 1'b1;
						em_d.first       = 1'b1;
						em_d.left        = cur_q.seg_cnt;
					end
					K_PASS_UP: begin
						em_d.dir = DIR_LINK;
					end
					K_SEGMENT: begin
						em_d.dir = DIR_LINK;
						if (st_rd_q.pending == '0) begin
							em_d.err = 1'b1;
						end else if (pend_dec != '0) begin
							// more segments outstanding, fold in and give nothing
							st_we            = 1'b1;
							st_wdata.active  = 1'b1;
							st_wdata.pending = pend_dec;
							mg_we            = 1'b1;
							mg_wdata.flits   = m_flits;
							mg_wdata.address = m_addr;
							em_load          = 1'b0;
							state_d          = B_IDLE;
						end else begin
							st_we      = 1'b1;
							em_d.addr  = m_addr;
							em_d.flits = m_flits;
						end
					end
					default: begin
					end
				endcase
			end
			B_EMIT: begin
				if (!out_valid_q || !result_stall) begin
					out_load = 1'b1;
					if (em_q.left == CNT_W'(1))
						state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing)
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q     <= q_item;
			cur_idx_q <= q_idx;
		end
		if (em_load) begin
			em_q <= em_d;
		end else if (out_load) begin
			em_q.left  <= em_q.left - CNT_W'(1);
			em_q.addr  <= em_q.addr + blk;
			em_q.first <= 1'b0;
		end
		if (out_load) begin
			out_q.direction   <= em_q.dir;
			out_q.vault       <= (em_q.dir == DIR_LINK) ? '0 :
				VAULT_OUT_W'(addr_sh[VAULT_W-1:0]);
			out_q.out_address <= em_q.addr;
			out_q.out_tag     <= em_q.tag;
			out_q.out_flits   <= em_q.flits;
			out_q.out_segment <= em_q.seg;
			out_q.out_first   <= em_q.first;
			out_q.last        <= em_q.left == CNT_W'(1);
			out_q.error       <= em_q.err;
		end
	end

	// tag tables, one write and one registered read each
	always_ff @(posedge clk) begin
		if (st_we)
			state_mem[st_widx] <= st_wdata;
		st_rd_q <= state_mem[cur_idx_q];
	end

	always_ff @(posedge clk) begin
		if (mg_we)
			merge_mem[cur_idx_q] <= mg_wdata;
		mg_rd_q <= merge_mem[cur_idx_q];
	end

endmodule
